[rtl/bbac_pkg.sv]
// ----------------------------------------------------------------------------
// bbac_pkg
// Shared types and constants of the buzzer beep and alarm controller.
// ----------------------------------------------------------------------------
package bbac_pkg;

    localparam int DurationBits = 16;

    localparam int CommandBits  = 3;
    localparam int DurInBits    = 16;
    localparam int CfgIdxBits   = 2;
    localparam int CfgDataBits  = 16;
    localparam int PhaseBits    = 8;
    localparam int BeepCntBits  = 4;
    localparam int MaxBeepBits  = 16;

    localparam logic [PhaseBits-1:0]   AlarmOnReset    = 8'd200;
    localparam logic [PhaseBits-1:0]   AlarmOffReset   = 8'd100;
    localparam logic [BeepCntBits-1:0] BeepTotalReset  = 4'd3;
    localparam logic [MaxBeepBits-1:0] MaxBeepReset    = 16'd60000;

    typedef enum logic [CommandBits-1:0] {
        CMD_TICK        = 3'd0,
        CMD_ON          = 3'd1,
        CMD_OFF         = 3'd2,
        CMD_TOGGLE      = 3'd3,
        CMD_SET_POWER   = 3'd4,
        CMD_BEEP        = 3'd5,
        CMD_ALARM_START = 3'd6,
        CMD_ALARM_STOP  = 3'd7
    } t_cmd;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_ALARM_ON   = 2'd0,
        CFG_ALARM_OFF  = 2'd1,
        CFG_BEEP_TOTAL = 2'd2,
        CFG_MAX_BEEP   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic buzzer_on;
        logic alarm_active;
        logic rejected;
    } t_result;

endpackage

[rtl/buzzer_beep_alarm_controller.sv]
// ----------------------------------------------------------------------------
// buzzer_beep_alarm_controller
// Buzzer drive from commands and 1 ms ticks, with timed beep and alarm run.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command or one tick
//   per word; every accepted word yields exactly one result word on the
//   output channel (o_out_valid / i_out_stall): buzzer level, alarm running
//   flag and a reject flag for an out-of-range beep duration.
//   Configuration writes use i_cfg_valid / o_cfg_ready with a register index
//   and data; ready is always high. Write only while the block is idle.
//   The result is registered (in the skid register while the output stalls).
//   Throughput: one word per cycle while o_in_stall is low; state update and
//   result come from one pass of logic between state and result registers.
//   A two-entry output stage (result register plus skid register) keeps
//   accepting while a result waits; o_in_stall rises only when both hold a
//   word, and falls again once the receiver takes one.
//   Reset (synchronous, active low) turns the buzzer off, ends any alarm,
//   disarms auto-off, empties the output stage and restores the register
//   defaults: on 200, off 100, beeps 3, longest beep 60000 ticks.
// ----------------------------------------------------------------------------
module buzzer_beep_alarm_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bbac_pkg::CommandBits-1:0]    i_command,
    input  logic                                i_power_value,
    input  logic [bbac_pkg::DurInBits-1:0]      i_duration_ticks,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_buzzer_on,
    output logic                                o_alarm_active,
    output logic                                o_rejected,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbac_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  logic [bbac_pkg::CfgDataBits-1:0]    i_cfg_data
);
    import bbac_pkg::*;

    logic [PhaseBits-1:0]    r_alarm_on;
    logic [PhaseBits-1:0]    r_alarm_off;
    logic [BeepCntBits-1:0]  r_beep_total;
    logic [MaxBeepBits-1:0]  r_max_beep;

    logic                    r_power;
    logic                    r_auto_run;
    logic [DurationBits-1:0] r_auto_left;
    logic                    r_alarm;
    logic [PhaseBits-1:0]    r_phase_left;
    logic [BeepCntBits-1:0]  r_beeps_done;

    logic                    n_power;
    logic                    n_auto_run;
    logic [DurationBits-1:0] n_auto_left;
    logic                    n_alarm;
    logic [PhaseBits-1:0]    n_phase_left;
    logic [BeepCntBits-1:0]  n_beeps_done;
    logic                    n_rejected;

    logic                    r_out_valid;
    t_result                 r_out;
    logic                    r_skid_valid;
    t_result                 r_skid;

    logic                    accept;
    logic                    out_free;
    logic [DurationBits-1:0] dur;
    t_result                 result;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign dur      = DurationBits'(i_duration_ticks);

    always_comb begin
        n_power      = r_power;
        n_auto_run   = r_auto_run;
        n_auto_left  = r_auto_left;
        n_alarm      = r_alarm;
        n_phase_left = r_phase_left;
        n_beeps_done = r_beeps_done;
        n_rejected   = 1'b0;
        case (t_cmd'(i_command))
            CMD_TICK: begin
                if (r_auto_run) begin
                    if (r_auto_left <= DurationBits'(1)) begin
                        n_auto_left = '0;
                        n_auto_run  = 1'b0;
                        n_power     = 1'b0;
                    end else begin
                        n_auto_left = r_auto_left - DurationBits'(1);
                    end
                end
                if (r_alarm) begin
                    if (r_phase_left <= PhaseBits'(1)) begin
                        n_phase_left = '0;
                        if (r_beeps_done < r_beep_total) begin
                            if (n_power) begin
                                n_power      = 1'b0;
                                n_phase_left = r_alarm_off;
                            end else begin
                                n_power      = 1'b1;
                                n_beeps_done = r_beeps_done + BeepCntBits'(1);
                                n_phase_left = r_alarm_on;
                            end
                        end else begin
                            n_power      = 1'b0;
                            n_alarm      = 1'b0;
                            n_beeps_done = '0;
                        end
                    end else begin
                        n_phase_left = r_phase_left - PhaseBits'(1);
                    end
                end
            end
            CMD_ON: begin
                n_power = 1'b1;
            end
            CMD_OFF: begin
                n_power     = 1'b0;
                n_auto_run  = 1'b0;
                n_auto_left = '0;
            end
            CMD_TOGGLE: begin
                n_power = !r_power;
            end
            CMD_SET_POWER: begin
                n_power = i_power_value;
            end
            CMD_BEEP: begin
                if ((dur == '0) || (32'(dur) > 32'(r_max_beep))) begin
                    n_rejected = 1'b1;
                end else begin
                    n_alarm      = 1'b0;
                    n_beeps_done = '0;
                    n_phase_left = '0;
                    n_power      = 1'b1;
                    n_auto_run   = 1'b1;
                    n_auto_left  = dur;
                end
            end
            CMD_ALARM_START: begin
                n_auto_run   = 1'b0;
                n_auto_left  = '0;
                n_alarm      = 1'b1;
                n_power      = 1'b1;
                n_beeps_done = BeepCntBits'(1);
                n_phase_left = r_alarm_on;
            end
            CMD_ALARM_STOP: begin
                if (r_alarm) begin
                    n_alarm      = 1'b0;
                    n_beeps_done = '0;
                    n_phase_left = '0;
                end
            end
            default: begin
            end
        endcase
        result.buzzer_on    = n_power;
        result.alarm_active = n_alarm;
        result.rejected     = n_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_on   <= AlarmOnReset;
            r_alarm_off  <= AlarmOffReset;
            r_beep_total <= BeepTotalReset;
            r_max_beep   <= MaxBeepReset;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALARM_ON:   r_alarm_on   <= i_cfg_data[PhaseBits-1:0];
                CFG_ALARM_OFF:  r_alarm_off  <= i_cfg_data[PhaseBits-1:0];
                CFG_BEEP_TOTAL: r_beep_total <= i_cfg_data[BeepCntBits-1:0];
                CFG_MAX_BEEP:   r_max_beep   <= i_cfg_data[MaxBeepBits-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power      <= 1'b0;
            r_auto_run   <= 1'b0;
            r_auto_left  <= '0;
            r_alarm      <= 1'b0;
            r_phase_left <= '0;
            r_beeps_done <= '0;
        end else if (accept) begin
            r_power      <= n_power;
            r_auto_run   <= n_auto_run;
            r_auto_left  <= n_auto_left;
            r_alarm      <= n_alarm;
            r_phase_left <= n_phase_left;
            r_beeps_done <= n_beeps_done;
        end
    end

    // advance the output stage: skid drains first, else a new word lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_buzzer_on    = r_out.buzzer_on;
    assign o_alarm_active = r_out.alarm_active;
    assign o_rejected     = r_out.rejected;
    assign o_cfg_ready    = 1'b1;

endmodule

[rtl/bbac_checker.sv]
// ----------------------------------------------------------------------------
// bbac_checker
// Port-level checks of the buzzer beep and alarm controller.
// ----------------------------------------------------------------------------
module bbac_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [bbac_pkg::CommandBits-1:0]    i_command,
    input logic                                i_power_value,
    input logic [bbac_pkg::DurInBits-1:0]      i_duration_ticks,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_buzzer_on,
    input logic                                o_alarm_active,
    input logic                                o_rejected,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [bbac_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input logic [bbac_pkg::CfgDataBits-1:0]    i_cfg_data
);
    import bbac_pkg::*;

    logic take_direct;

    assign take_direct = i_in_valid && !o_in_stall && !o_out_valid;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output stage not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_buzzer_on) && $stable(o_alarm_active)
            && $stable(o_rejected))
        else $error("stalled result changed");

    a_alarm_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_direct && (i_command == CMD_ALARM_START) |=>
            o_out_valid && o_buzzer_on && o_alarm_active && !o_rejected)
        else $error("alarm start did not sound and run");

    a_no_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_direct && (i_command != CMD_BEEP) |=> o_out_valid && !o_rejected)
        else $error("reject flag on a non-beep word");

    a_zero_beep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_direct && (i_command == CMD_BEEP) && (i_duration_ticks == '0) |=>
            o_out_valid && o_rejected)
        else $error("zero-length beep not rejected");

endmodule

bind buzzer_beep_alarm_controller bbac_checker u_bbac_checker (.*);
